/* rtl/core/assert_macros.svh */
// Assertion macros shared by the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante holds in a cycle -> cons holds in the same cycle
`define AEPS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");
// ante holds in a cycle -> cons holds in the next cycle
`define AEPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");
`else
`define AEPS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define AEPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/aeps_pkg.sv */
// Package: field widths, operation and status codes, control structs
package aeps_pkg;

   localparam int OP_W    = 3;
   localparam int TID_W   = 6;
   localparam int CRED_W  = 4;
   localparam int STAT_W  = 2;

   localparam int PRIORITY_LEVELS_DEF = 8;
   localparam int MAX_THREADS_DEF     = 64;

   localparam logic [OP_W-1:0] OP_INSERT_READY   = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT_EXPIRED = 3'd1;
   localparam logic [OP_W-1:0] OP_DISPATCH       = 3'd2;
   localparam logic [OP_W-1:0] OP_PEEK           = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY          = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_PRIO  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request fields, start memory read
      logic execute;   // apply the operation, load the result register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;  // result register can take a new item this cycle
   } dp_stat_type;

endpackage

/* rtl/core/active_expired_priority_scheduler.sv */
// Result item: loaded by execute, which follows capture and waits while a result is stalled.
// Items are taken one at a time: capture + memory read, then execute + result load.
// The link/credit memory read in capture has registered data, so execute is a separate step.
// Reset (sync, high): all queues empty, bank 0 active, no thread queued, no result pending.
// Link and credit memories are not cleared; only entries of queued threads are used.
module active_expired_priority_scheduler #(
   parameter int PRIORITY_LEVELS = aeps_pkg::PRIORITY_LEVELS_DEF,
   parameter int MAX_THREADS     = aeps_pkg::MAX_THREADS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [aeps_pkg::OP_W-1:0]     req_operation,
   input  logic [aeps_pkg::TID_W-1:0]    req_tid,
   input  logic [aeps_pkg::CRED_W-1:0]   req_credit_now,
   input  logic [aeps_pkg::CRED_W-1:0]   req_credit_create,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [aeps_pkg::STAT_W-1:0]   rsp_status,
   output logic [aeps_pkg::TID_W-1:0]    rsp_out_tid,
   output logic [aeps_pkg::CRED_W-1:0]   rsp_out_credit,
   output logic                          rsp_nothing_ready
);

   // The controller takes one item at a time: capture in idle, execute once the
   // result register is free. The result register decouples the two channels,
   // so a new item is taken while the previous result still waits; execute then
   // holds until that result leaves.
   //
   // Queues are linked lists: head/tail per (bank, level) in flops, next-pointers
   // and per-thread credits in RAMs. Dispatch/peek read the head thread's link and
   // credit during capture; a dispatch's bank swap for an all-empty active bank happens
   // there too, so execute sees the swapped bank.

   aeps_pkg::ctl_cmd_type cmd;
   aeps_pkg::dp_stat_type stat;

   aeps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   aeps_dp #(
      .PRIORITY_LEVELS (PRIORITY_LEVELS),
      .MAX_THREADS     (MAX_THREADS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_tid           (req_tid),
      .req_credit_now    (req_credit_now),
      .req_credit_create (req_credit_create),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_tid       (rsp_out_tid),
      .rsp_out_credit    (rsp_out_credit),
      .rsp_nothing_ready (rsp_nothing_ready)
   );

endmodule

/* rtl/core/aeps_ram.sv */
// Generic single-write, single-read RAM with registered read data
module aeps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/aeps_ctrl.sv */
// Controller: sequences request capture and execution of one item
module aeps_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  aeps_pkg::dp_stat_type    stat,
   output aeps_pkg::ctl_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait for a free result slot before touching state
            if (stat.out_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/aeps_dp.sv */
// Datapath: queue heads/tails, bank and map registers, link and credit memories
`include "assert_macros.svh"
module aeps_dp #(
   parameter int PRIORITY_LEVELS = aeps_pkg::PRIORITY_LEVELS_DEF,
   parameter int MAX_THREADS     = aeps_pkg::MAX_THREADS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  aeps_pkg::ctl_cmd_type         cmd,
   output aeps_pkg::dp_stat_type         stat,
   input  logic [aeps_pkg::OP_W-1:0]     req_operation,
   input  logic [aeps_pkg::TID_W-1:0]    req_tid,
   input  logic [aeps_pkg::CRED_W-1:0]   req_credit_now,
   input  logic [aeps_pkg::CRED_W-1:0]   req_credit_create,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [aeps_pkg::STAT_W-1:0]   rsp_status,
   output logic [aeps_pkg::TID_W-1:0]    rsp_out_tid,
   output logic [aeps_pkg::CRED_W-1:0]   rsp_out_credit,
   output logic                          rsp_nothing_ready
);

   localparam int LW  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int TAW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

   // captured request
   logic [aeps_pkg::OP_W-1:0]   op_ff;
   logic [aeps_pkg::TID_W-1:0]  tid_ff;
   logic [aeps_pkg::CRED_W-1:0] cnow_ff;
   logic [aeps_pkg::CRED_W-1:0] ccre_ff;
   logic                        sel_bank_ff;
   logic [LW-1:0]               sel_lvl_ff;
   logic                        found_ff;

   // scheduler state
   logic                        bank_ff, bank_in;
   logic [PRIORITY_LEVELS-1:0]  ne_ff [2];
   logic [PRIORITY_LEVELS-1:0]  ne_in [2];
   logic [MAX_THREADS-1:0]      queued_ff, queued_in;
   logic [TAW-1:0]              head_ff [2][PRIORITY_LEVELS];
   logic [TAW-1:0]              head_in [2][PRIORITY_LEVELS];
   logic [TAW-1:0]              tail_ff [2][PRIORITY_LEVELS];
   logic [TAW-1:0]              tail_in [2][PRIORITY_LEVELS];

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [aeps_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [aeps_pkg::TID_W-1:0]  rsp_tid_ff, rsp_tid_in;
   logic [aeps_pkg::CRED_W-1:0] rsp_cred_ff, rsp_cred_in;
   logic                        rsp_nr_ff, rsp_nr_in;

   // top-level search
   logic                        bank_oth;
   logic [LW-1:0]               lvl_act, lvl_oth;
   logic                        found_act, found_oth;
   logic                        is_dispatch, use_other;
   logic                        sel_bank;
   logic [LW-1:0]               sel_lvl;
   logic                        found;

   // execute-side decode
   logic [TAW-1:0]              tid_addr;
   logic                        now_ok, create_ok, tid_ok;
   logic                        is_insert, bad_prio, dup, ins_ok, to_active;
   logic                        ins_bank;
   logic [LW-1:0]               ins_lvl;
   logic [aeps_pkg::CRED_W-1:0] cred_wr;
   logic [TAW-1:0]              pop_tid;
   logic                        pop;
   logic                        link_wr_en;

   // memories
   logic [TAW-1:0]              link_rd;
   logic [aeps_pkg::CRED_W-1:0] cred_rd;
   logic [TAW-1:0]              rd_addr;

   // checks
   logic                        all_queues_empty;
   logic                        no_thread_queued;

   assign bank_oth = ~bank_ff;

   // highest nonempty level of each bank
   always_comb begin
      lvl_act   = '0;
      lvl_oth   = '0;
      found_act = 1'b0;
      found_oth = 1'b0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
         if (ne_ff[bank_ff][i]) begin
            lvl_act   = LW'(i);
            found_act = 1'b1;
         end
         if (ne_ff[bank_oth][i]) begin
            lvl_oth   = LW'(i);
            found_oth = 1'b1;
         end
      end
   end

   // dispatch falls over to the other bank when the active one is empty
   assign is_dispatch = (req_operation == aeps_pkg::OP_DISPATCH);
   assign use_other   = is_dispatch && !found_act;
   assign sel_bank    = use_other ? bank_oth : bank_ff;
   assign sel_lvl     = use_other ? lvl_oth : lvl_act;
   assign found       = use_other ? found_oth : found_act;
   assign rd_addr     = head_ff[sel_bank][sel_lvl];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         tid_ff      <= req_tid;
         cnow_ff     <= req_credit_now;
         ccre_ff     <= req_credit_create;
         sel_bank_ff <= sel_bank;
         sel_lvl_ff  <= sel_lvl;
         found_ff    <= found;
      end
   end

   // request checks
   assign tid_addr  = TAW'(tid_ff);
   assign now_ok    = (32'(cnow_ff) <= 32'(PRIORITY_LEVELS));
   assign create_ok = (ccre_ff != '0) && (32'(ccre_ff) <= 32'(PRIORITY_LEVELS));
   assign tid_ok    = (32'(tid_ff) < 32'(MAX_THREADS));
   assign is_insert = (op_ff == aeps_pkg::OP_INSERT_READY) ||
                      (op_ff == aeps_pkg::OP_INSERT_EXPIRED);
   assign bad_prio  = !now_ok || !tid_ok ||
                      (!create_ok && ((op_ff == aeps_pkg::OP_INSERT_EXPIRED) ||
                                      (cnow_ff == '0)));
   assign dup       = queued_ff[tid_addr];
   assign ins_ok    = cmd.execute && is_insert && !bad_prio && !dup;
   assign to_active = (op_ff == aeps_pkg::OP_INSERT_READY) && (cnow_ff != '0);
   assign ins_bank  = to_active ? bank_ff : bank_oth;
   assign ins_lvl   = to_active ? LW'(cnow_ff - 4'd1) : LW'(ccre_ff - 4'd1);
   // a ready insert with no credit left reloads from the creation credit
   assign cred_wr   = (op_ff == aeps_pkg::OP_INSERT_READY && cnow_ff == '0) ?
                      ccre_ff : cnow_ff;
   assign link_wr_en = ins_ok && ne_ff[ins_bank][ins_lvl];

   assign pop_tid = head_ff[sel_bank_ff][sel_lvl_ff];
   assign pop     = cmd.execute && (op_ff == aeps_pkg::OP_DISPATCH) && found_ff;

   aeps_ram #(
      .WIDTH (TAW),
      .DEPTH (MAX_THREADS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (tail_ff[ins_bank][ins_lvl]),
      .wr_data (tid_addr),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   aeps_ram #(
      .WIDTH (aeps_pkg::CRED_W),
      .DEPTH (MAX_THREADS)
   ) u_cred_ram (
      .clock   (clock),
      .wr_en   (ins_ok),
      .wr_addr (tid_addr),
      .wr_data (cred_wr),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (cred_rd)
   );

   // state update
   always_comb begin
      bank_in   = bank_ff;
      ne_in     = ne_ff;
      queued_in = queued_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      if (cmd.capture && is_dispatch && !found_act) begin
         bank_in = bank_oth;
      end
      if (ins_ok) begin
         if (!ne_ff[ins_bank][ins_lvl]) begin
            head_in[ins_bank][ins_lvl] = tid_addr;
         end
         tail_in[ins_bank][ins_lvl]  = tid_addr;
         ne_in[ins_bank][ins_lvl]    = 1'b1;
         queued_in[tid_addr]         = 1'b1;
      end
      if (pop) begin
         if (pop_tid == tail_ff[sel_bank_ff][sel_lvl_ff]) begin
            ne_in[sel_bank_ff][sel_lvl_ff] = 1'b0;
         end else begin
            head_in[sel_bank_ff][sel_lvl_ff] = link_rd;
         end
         queued_in[pop_tid] = 1'b0;
      end
   end

   // result
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_status_in = aeps_pkg::STAT_EMPTY;
      rsp_tid_in    = '0;
      rsp_cred_in   = '0;
      if (is_insert) begin
         if (bad_prio) begin
            rsp_status_in = aeps_pkg::STAT_BAD_PRIO;
         end else if (dup) begin
            rsp_status_in = aeps_pkg::STAT_DUPLICATE;
         end else begin
            rsp_status_in = aeps_pkg::STAT_OK;
         end
      end else if ((op_ff == aeps_pkg::OP_DISPATCH || op_ff == aeps_pkg::OP_PEEK) &&
                   found_ff) begin
         rsp_status_in = aeps_pkg::STAT_OK;
         rsp_tid_in    = aeps_pkg::TID_W'(pop_tid);
         rsp_cred_in   = cred_rd;
      end else if (op_ff == aeps_pkg::OP_QUERY && tid_ok && dup) begin
         rsp_status_in = aeps_pkg::STAT_OK;
      end
      rsp_nr_in = (ne_in[0] == '0) && (ne_in[1] == '0);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         ne_ff        <= '{default: '0};
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bank_ff      <= bank_in;
         ne_ff        <= ne_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (cmd.execute) begin
         rsp_status_ff <= rsp_status_in;
         rsp_tid_ff    <= rsp_tid_in;
         rsp_cred_ff   <= rsp_cred_in;
         rsp_nr_ff     <= rsp_nr_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_tid       = rsp_tid_ff;
   assign rsp_out_credit    = rsp_cred_ff;
   assign rsp_nothing_ready = rsp_nr_ff;

   assign all_queues_empty = (ne_ff[0] == '0) && (ne_ff[1] == '0);
   assign no_thread_queued = (queued_ff == '0);

   // all queues empty exactly when no thread is marked queued
   `AEPS_ASSERT_IMPL(a_map_matches_queues, clock, reset, 1'b1, all_queues_empty == no_thread_queued)
   // a popped head is always a queued thread
   `AEPS_ASSERT_IMPL(a_pop_is_queued, clock, reset, pop, queued_ff[pop_tid])
   // an insert never lands on a thread already queued
   `AEPS_ASSERT_IMPL(a_insert_fresh, clock, reset, ins_ok, !queued_ff[tid_addr])
   // every executed item leaves a result behind
   `AEPS_ASSERT_NEXT(a_exec_result, clock, reset, cmd.execute, rsp_valid_ff)

endmodule

/* tb/active_expired_priority_scheduler_tb.sv */
// Testbench for the active/expired priority scheduler: random and directed calls, scoreboard
`timescale 1ns / 1ps

module active_expired_priority_scheduler_tb;

   localparam int LEVELS  = aeps_pkg::PRIORITY_LEVELS_DEF;
   localparam int THREADS = aeps_pkg::MAX_THREADS_DEF;
   localparam int QUEUES  = 2 * LEVELS;

   // codes 5..7 are unused by the block; it must leave its state alone
   localparam logic [aeps_pkg::OP_W-1:0] OP_RESERVED_LO = 3'd5;
   localparam logic [aeps_pkg::OP_W-1:0] OP_RESERVED_HI = 3'd7;

   localparam int RANDOM_CALLS   = 1600;
   localparam int IDLE_PERCENT   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   // accepted-call window in which neither side idles
   localparam int BUSY_FROM      = 500;
   localparam int BUSY_TO        = 850;

   typedef struct packed {
      logic [aeps_pkg::OP_W-1:0]   operation;
      logic [aeps_pkg::TID_W-1:0]  tid;
      logic [aeps_pkg::CRED_W-1:0] credit_now;
      logic [aeps_pkg::CRED_W-1:0] credit_create;
   } sched_call_type;

   typedef struct packed {
      logic [aeps_pkg::STAT_W-1:0] status;
      logic [aeps_pkg::TID_W-1:0]  tid;
      logic [aeps_pkg::CRED_W-1:0] credit;
      logic                        nothing_ready;
   } sched_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [aeps_pkg::OP_W-1:0]     req_operation;
   logic [aeps_pkg::TID_W-1:0]    req_tid;
   logic [aeps_pkg::CRED_W-1:0]   req_credit_now;
   logic [aeps_pkg::CRED_W-1:0]   req_credit_create;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [aeps_pkg::STAT_W-1:0]   rsp_status;
   logic [aeps_pkg::TID_W-1:0]    rsp_out_tid;
   logic [aeps_pkg::CRED_W-1:0]   rsp_out_credit;
   logic                          rsp_nothing_ready;

   // call currently offered on the request channel
   sched_call_type cur_call = '0;

   assign req_operation     = cur_call.operation;
   assign req_tid           = cur_call.tid;
   assign req_credit_now    = cur_call.credit_now;
   assign req_credit_create = cur_call.credit_create;

   active_expired_priority_scheduler dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_tid           (req_tid),
      .req_credit_now    (req_credit_now),
      .req_credit_create (req_credit_create),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_tid       (rsp_out_tid),
      .rsp_out_credit    (rsp_out_credit),
      .rsp_nothing_ready (rsp_nothing_ready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   sched_call_type   pending_calls[$];
   sched_result_type results_due[$];
   int               accepted_calls = 0;
   int               fail_count     = 0;
   int               quiet_cycles   = 0;
   logic             no_idling;

   assign no_idling = accepted_calls >= BUSY_FROM && accepted_calls < BUSY_TO;

   // ------------------------------------------------------------------
   // Scheduler shadow. Queue index = bank * LEVELS + (level - 1); each
   // queue is a singly linked list threaded through link_mem.
   // ------------------------------------------------------------------
   logic [aeps_pkg::TID_W-1:0]  link_mem   [THREADS] = '{default: '0};
   logic [aeps_pkg::CRED_W-1:0] credit_mem [THREADS] = '{default: '0};
   logic [aeps_pkg::TID_W-1:0]  queue_head [QUEUES]  = '{default: '0};
   logic [aeps_pkg::TID_W-1:0]  queue_tail [QUEUES]  = '{default: '0};
   logic [QUEUES-1:0]           queue_busy    = '0;
   logic                        active_bank   = 1'b0;
   logic [THREADS-1:0]          thread_queued = '0;

   function automatic void queue_append(int q, logic [aeps_pkg::TID_W-1:0] tid);
      if (queue_busy[q]) begin
         link_mem[queue_tail[q]] = tid;
      end else begin
         queue_head[q] = tid;
      end
      queue_tail[q]      = tid;
      queue_busy[q]      = 1'b1;
      thread_queued[tid] = 1'b1;
   endfunction

   // queue index of the highest nonempty level of the active bank, -1 when the bank is empty
   function automatic int top_ready_queue();
      int found;
      found = -1;
      for (int lvl = LEVELS - 1; lvl >= 0 && found < 0; lvl--)
         if (queue_busy[int'(active_bank) * LEVELS + lvl])
            found = int'(active_bank) * LEVELS + lvl;
      return found;
   endfunction

   function automatic sched_result_type schedule_apply(sched_call_type c);
      sched_result_type           res;
      logic                       create_ok;
      logic                       now_ok;
      int                         q;
      logic [aeps_pkg::TID_W-1:0] t;
      res           = '0;
      res.status    = aeps_pkg::STAT_EMPTY;
      create_ok     = c.credit_create >= 1 && c.credit_create <= LEVELS;
      now_ok        = c.credit_now <= LEVELS;
      case (c.operation)
         aeps_pkg::OP_INSERT_READY, aeps_pkg::OP_INSERT_EXPIRED: begin
            // priority checks win over the duplicate check
            if (!now_ok || int'(c.tid) >= THREADS ||
                (!create_ok && (c.operation == aeps_pkg::OP_INSERT_EXPIRED ||
                                c.credit_now == 0))) begin
               res.status = aeps_pkg::STAT_BAD_PRIO;
            end else if (thread_queued[c.tid]) begin
               res.status = aeps_pkg::STAT_DUPLICATE;
            end else if (c.operation == aeps_pkg::OP_INSERT_READY && c.credit_now != 0) begin
               credit_mem[c.tid] = c.credit_now;
               queue_append(int'(active_bank) * LEVELS + int'(c.credit_now) - 1, c.tid);
               res.status = aeps_pkg::STAT_OK;
            end else begin
               // out of credit: reload from creation credit; expired insert keeps credit_now
               credit_mem[c.tid] = (c.operation == aeps_pkg::OP_INSERT_READY) ?
                                   c.credit_create : c.credit_now;
               queue_append(int'(!active_bank) * LEVELS + int'(c.credit_create) - 1,
                            c.tid);
               res.status = aeps_pkg::STAT_OK;
            end
         end
         aeps_pkg::OP_DISPATCH: begin
            q = top_ready_queue();
            if (q < 0) begin
               // active bank drained: swap, even when both banks are empty
               active_bank = ~active_bank;
               q = top_ready_queue();
            end
            if (q >= 0) begin
               t = queue_head[q];
               if (t == queue_tail[q]) begin
                  queue_busy[q] = 1'b0;
               end else begin
                  queue_head[q] = link_mem[t];
               end
               thread_queued[t] = 1'b0;
               res.status = aeps_pkg::STAT_OK;
               res.tid    = t;
               res.credit = credit_mem[t];
            end
         end
         aeps_pkg::OP_PEEK: begin
            q = top_ready_queue();
            if (q >= 0) begin
               res.status = aeps_pkg::STAT_OK;
               res.tid    = queue_head[q];
               res.credit = credit_mem[queue_head[q]];
            end
         end
         aeps_pkg::OP_QUERY: begin
            if (int'(c.tid) < THREADS && thread_queued[c.tid]) begin
               res.status = aeps_pkg::STAT_OK;
            end
         end
         default: begin
         end
      endcase
      res.nothing_ready = (queue_busy == '0);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic push_call(logic [aeps_pkg::OP_W-1:0] op, int tid, int cnow, int ccre);
      sched_call_type c;
      c.operation     = op;
      c.tid           = tid[aeps_pkg::TID_W-1:0];
      c.credit_now    = cnow[aeps_pkg::CRED_W-1:0];
      c.credit_create = ccre[aeps_pkg::CRED_W-1:0];
      pending_calls.push_back(c);
   endtask

   function automatic int bad_create_credit();
      return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(LEVELS + 1, 15);
   endfunction

   task automatic build_directed();
      push_call(aeps_pkg::OP_DISPATCH, 0, 0, 0);          // both banks empty: swap, none
      push_call(aeps_pkg::OP_PEEK, 63, 15, 15);           // peek on empty
      push_call(aeps_pkg::OP_QUERY, 0, 0, 0);             // not queued
      push_call(aeps_pkg::OP_INSERT_READY, 63, LEVELS, 15); // top level, create ignored
      push_call(aeps_pkg::OP_INSERT_READY, 0, 1, 0);      // bottom level
      push_call(aeps_pkg::OP_INSERT_READY, 5, 0, LEVELS); // no credit left: expired, reload
      push_call(aeps_pkg::OP_INSERT_EXPIRED, 6, 3, 1);    // expired insert keeps credit_now
      push_call(aeps_pkg::OP_INSERT_EXPIRED, 10, 0, 4);   // stored credit zero
      push_call(aeps_pkg::OP_INSERT_READY, 63, 2, 2);     // duplicate
      push_call(aeps_pkg::OP_INSERT_READY, 63, 15, 2);    // bad priority beats duplicate
      push_call(aeps_pkg::OP_INSERT_READY, 20, 0, 0);     // zero credit, bad creation credit
      push_call(aeps_pkg::OP_INSERT_EXPIRED, 21, 2, 9);   // creation credit out of range
      push_call(aeps_pkg::OP_INSERT_EXPIRED, 22, 9, 3);   // current credit out of range
      push_call(aeps_pkg::OP_INSERT_EXPIRED, 5, 1, 2);    // duplicate sitting in expired bank
      push_call(aeps_pkg::OP_QUERY, 63, 0, 0);
      push_call(aeps_pkg::OP_QUERY, 20, 15, 15);
      push_call(aeps_pkg::OP_PEEK, 0, 0, 0);
      push_call(OP_RESERVED_LO, 63, 15, 15);
      push_call(OP_RESERVED_LO + 3'd1, 63, 15, 15);
      push_call(OP_RESERVED_HI, 63, 15, 15);
      // drain active, then swap into expired: 5, 10, 6, then empty
      repeat (6) push_call(aeps_pkg::OP_DISPATCH, 0, 0, 0);
      push_call(aeps_pkg::OP_PEEK, 0, 0, 0);
   endtask

   // Segments are picked at random among filling, draining and mixed traffic so the
   // queues reach full occupancy and drain through bank swaps repeatedly.
   task automatic build_random();
      int made;
      int seg_kind;
      int roll;
      int ready_w, expired_w, dispatch_w, peek_w;
      int cnow;
      made = 0;
      while (made < RANDOM_CALLS) begin
         seg_kind = $urandom_range(0, 2);
         case (seg_kind)
            0:       begin ready_w = 55; expired_w = 20; dispatch_w = 10; peek_w = 7;  end
            1:       begin ready_w = 15; expired_w = 10; dispatch_w = 50; peek_w = 13; end
            default: begin ready_w = 30; expired_w = 15; dispatch_w = 30; peek_w = 12; end
         endcase
         repeat ($urandom_range(20, 80)) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               // malformed calls
               case ($urandom_range(0, 3))
                  0: push_call(aeps_pkg::OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI)),
                               $urandom_range(0, 63), $urandom_range(0, 15),
                               $urandom_range(0, 15));
                  1: push_call($urandom_range(0, 1) ? aeps_pkg::OP_INSERT_READY :
                                                      aeps_pkg::OP_INSERT_EXPIRED,
                               $urandom_range(0, 63), $urandom_range(LEVELS + 1, 15),
                               $urandom_range(0, 15));
                  2: push_call(aeps_pkg::OP_INSERT_READY, $urandom_range(0, 63), 0,
                               bad_create_credit());
                  default: push_call(aeps_pkg::OP_INSERT_EXPIRED, $urandom_range(0, 63),
                                     $urandom_range(0, LEVELS), bad_create_credit());
               endcase
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < ready_w) begin
                  cnow = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, LEVELS);
                  // creation credit only matters when the thread is out of credit
                  push_call(aeps_pkg::OP_INSERT_READY, $urandom_range(0, 63), cnow,
                            cnow == 0 ? $urandom_range(1, LEVELS) : $urandom_range(0, 15));
               end else if (roll < ready_w + expired_w) begin
                  push_call(aeps_pkg::OP_INSERT_EXPIRED, $urandom_range(0, 63),
                            $urandom_range(0, LEVELS), $urandom_range(1, LEVELS));
               end else if (roll < ready_w + expired_w + dispatch_w) begin
                  push_call(aeps_pkg::OP_DISPATCH, $urandom_range(0, 63),
                            $urandom_range(0, 15), $urandom_range(0, 15));
               end else if (roll < ready_w + expired_w + dispatch_w + peek_w) begin
                  push_call(aeps_pkg::OP_PEEK, $urandom_range(0, 63), $urandom_range(0, 15),
                            $urandom_range(0, 15));
               end else begin
                  push_call(aeps_pkg::OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 15),
                            $urandom_range(0, 15));
               end
            end
            if (pending_calls[$].operation < OP_RESERVED_LO)
               made++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver: an item is predicted the moment it is accepted; a
   // stalled item is held unchanged. Valid never looks at stall except
   // to know whether the current item has gone.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            results_due.push_back(schedule_apply(cur_call));
            accepted_calls <= accepted_calls + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_calls.size() != 0 &&
                (no_idling || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               cur_call  <= pending_calls.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: in-order compare against the oldest prediction
   // ------------------------------------------------------------------
   task automatic check_result(sched_result_type got);
      sched_result_type want;
      if (results_due.size() == 0) begin
         $error("result item with nothing outstanding: status %0d thread %0d",
                got.status, got.tid);
         fail_count++;
      end else begin
         want = results_due.pop_front();
         if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
         end
         if (got.tid != want.tid) begin
            $error("out_tid: expected %0d, got %0d", want.tid, got.tid);
            fail_count++;
         end
         if (got.credit != want.credit) begin
            $error("out_credit: expected %0d, got %0d", want.credit, got.credit);
            fail_count++;
         end
         if (got.nothing_ready != want.nothing_ready) begin
            $error("nothing_ready: expected %0d, got %0d",
                   want.nothing_ready, got.nothing_ready);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result({rsp_status, rsp_out_tid, rsp_out_credit, rsp_nothing_ready});
         rsp_stall <= !no_idling && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // watchdog: too long without any handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      build_directed();
      build_random();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_calls.size() != 0 || req_valid || results_due.size() != 0)
         @(posedge clock);
      // run on past the last expected result to catch stray results
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
